// File: hw/rtl/text_console_cursor_scroll_assert.svh
// ----------------------------------------------------------------------------
// Text console assertion macros
// Shorthand for clocked checks that are disabled while rst is high.
// The file that uses them provides clk and rst.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define TCCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tccs check failed");

// Consequent must hold in the cycle after the antecedent
`define TCCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tccs check failed");

`endif

// File: hw/rtl/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types and constants of the text console cell engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tccs_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // Field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int POS_W  = 11;
  localparam int IDX_W  = 11;
  localparam int BYTE_W = 8;

  // Character codes and blank cell
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] BLANK_CHAR = 8'd32;
  localparam logic [BYTE_W-1:0] BLANK_ATTR = 8'd7;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RD_WAIT,
    ST_COPY,
    ST_DRAIN,
    ST_FILL,
    ST_CLEAR,
    ST_FINISH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // latch the accepted request
    logic put_exec;    // apply put to cursor and cell
    logic clear_init;  // home cursor, start clear sweep
    logic rd_issue;    // read the requested cell
    logic copy_step;   // scroll: read one cell a row below
    logic fill_init;   // scroll: point sweep at bottom row
    logic blank_step;  // write one blank cell
    logic out_load;    // move result into output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_t cmd;
    logic need_scroll;
    logic copy_last;
    logic blank_last;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/tccs_ctrl.sv
// ----------------------------------------------------------------------------
// tccs_ctrl
// Sequencer of the text console: decodes requests and steps the sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire tccs_pkg::dp_stat_t stat,
  output tccs_pkg::dp_cmd_t      cmd
);

  tccs_pkg::state_t state;
  tccs_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tccs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tccs_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = tccs_pkg::ST_DECODE;
      end
      tccs_pkg::ST_DECODE: begin
        case (stat.cmd)
          tccs_pkg::CMD_PUT: begin
            state_next = stat.need_scroll ? tccs_pkg::ST_COPY : tccs_pkg::ST_FINISH;
          end
          tccs_pkg::CMD_CLEAR: state_next = tccs_pkg::ST_CLEAR;
          tccs_pkg::CMD_READ:  state_next = tccs_pkg::ST_RD_WAIT;
          default:             state_next = tccs_pkg::ST_FINISH;
        endcase
      end
      tccs_pkg::ST_RD_WAIT: state_next = tccs_pkg::ST_FINISH;
      tccs_pkg::ST_COPY: begin
        if (stat.copy_last) state_next = tccs_pkg::ST_DRAIN;
      end
      tccs_pkg::ST_DRAIN: state_next = tccs_pkg::ST_FILL;
      tccs_pkg::ST_FILL: begin
        if (stat.blank_last) state_next = tccs_pkg::ST_FINISH;
      end
      tccs_pkg::ST_CLEAR: begin
        if (stat.blank_last) state_next = tccs_pkg::ST_FINISH;
      end
      tccs_pkg::ST_FINISH: begin
        if (!stat.out_busy) state_next = tccs_pkg::ST_IDLE;
      end
      default: state_next = tccs_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_tready       = (state == tccs_pkg::ST_IDLE);
    cmd            = '0;
    cmd.load       = (state == tccs_pkg::ST_IDLE) && s_tvalid;
    cmd.put_exec   = (state == tccs_pkg::ST_DECODE) && (stat.cmd == tccs_pkg::CMD_PUT);
    cmd.clear_init = (state == tccs_pkg::ST_DECODE) && (stat.cmd == tccs_pkg::CMD_CLEAR);
    cmd.rd_issue   = (state == tccs_pkg::ST_DECODE) && (stat.cmd == tccs_pkg::CMD_READ);
    cmd.copy_step  = (state == tccs_pkg::ST_COPY);
    cmd.fill_init  = (state == tccs_pkg::ST_DRAIN);
    cmd.blank_step = (state == tccs_pkg::ST_FILL) || (state == tccs_pkg::ST_CLEAR);
    cmd.out_load   = (state == tccs_pkg::ST_FINISH) && !stat.out_busy;
  end

endmodule

`default_nettype wire

// File: hw/rtl/tccs_datapath.sv
// ----------------------------------------------------------------------------
// tccs_datapath
// Cell memory, cursor registers, sweep counter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [23:0]       s_tdata,
  input  wire logic [1:0]        s_tuser,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [31:0]            m_tdata,
  output logic [0:0]             m_tuser,
  input  wire tccs_pkg::dp_cmd_t cmd,
  output tccs_pkg::dp_stat_t     stat
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int PF_W   = tccs_pkg::ROW_W + tccs_pkg::COL_W + 1;
  localparam int CW1    = tccs_pkg::COL_W + 1;
  localparam int RW1    = tccs_pkg::ROW_W + 1;
  localparam int BW     = tccs_pkg::BYTE_W;

  // Cell memory, character and attribute planes
  logic [BW-1:0] char_mem [CELLS];
  logic [BW-1:0] attr_mem [CELLS];

  // Request registers
  tccs_pkg::cmd_t                 cmd_q;
  logic [BW-1:0]                  char_q;
  logic [tccs_pkg::IDX_W-1:0]     idx_q;
  logic                           hit_q;

  // Cursor and sweep
  logic [tccs_pkg::COL_W-1:0]     col;
  logic [tccs_pkg::ROW_W-1:0]     row;
  logic [ADDR_W-1:0]              sweep;
  logic                           scrolled_q;
  logic                           copy_pend;
  logic [ADDR_W-1:0]              copy_addr;
  logic [BW-1:0]                  rd_char;
  logic [BW-1:0]                  rd_attr;

  // Output register
  logic [tccs_pkg::POS_W-1:0]     out_pos;
  logic [BW-1:0]                  out_char;
  logic [BW-1:0]                  out_attr;
  logic                           out_scrolled;

  logic [PF_W-1:0]                pos_full;
  logic                           is_cr;
  logic                           is_lf;
  logic [CW1-1:0]                 col_a;
  logic [RW1-1:0]                 row_a;
  logic [CW1-1:0]                 col_b;
  logic [RW1-1:0]                 row_b;
  logic                           need_scroll;
  logic [tccs_pkg::ROW_W-1:0]     row_new;
  logic [tccs_pkg::IDX_W-1:0]     in_idx;
  tccs_pkg::cmd_t                 in_cmd;

  logic                           char_we;
  logic                           attr_we;
  logic [ADDR_W-1:0]              wr_addr;
  logic [BW-1:0]                  wr_char;
  logic [BW-1:0]                  wr_attr;
  logic                           rd_en;
  logic [ADDR_W-1:0]              rd_addr;

  assign in_cmd = tccs_pkg::cmd_t'(s_tuser);
  assign in_idx = s_tdata[18:8];

  // Linear cursor position
  assign pos_full = PF_W'(row) * PF_W'(COLUMNS) + PF_W'(col);

  // Put: control codes, column advance, wrap and scroll detect
  always_comb begin
    is_cr = (char_q == tccs_pkg::CHAR_CR);
    is_lf = (char_q == tccs_pkg::CHAR_LF);
    if (is_cr) begin
      col_a = '0;
      row_a = RW1'(row);
    end else if (is_lf) begin
      col_a = '0;
      row_a = RW1'(row) + RW1'(1);
    end else begin
      col_a = CW1'(col) + CW1'(1);
      row_a = RW1'(row);
    end
    if (col_a >= CW1'(COLUMNS)) begin
      col_b = '0;
      row_b = row_a + RW1'(1);
    end else begin
      col_b = col_a;
      row_b = row_a;
    end
    need_scroll = (row_b >= RW1'(ROWS));
    row_new     = need_scroll ? tccs_pkg::ROW_W'(ROWS - 1) : row_b[tccs_pkg::ROW_W-1:0];
  end

  // Memory write port select
  always_comb begin
    char_we = 1'b0;
    attr_we = 1'b0;
    wr_addr = sweep;
    wr_char = tccs_pkg::BLANK_CHAR;
    wr_attr = tccs_pkg::BLANK_ATTR;
    if (copy_pend) begin
      char_we = 1'b1;
      attr_we = 1'b1;
      wr_addr = copy_addr;
      wr_char = rd_char;
      wr_attr = rd_attr;
    end else if (cmd.blank_step) begin
      char_we = 1'b1;
      attr_we = 1'b1;
    end else if (cmd.put_exec && !is_cr && !is_lf) begin
      char_we = 1'b1;
      wr_addr = ADDR_W'(pos_full);
      wr_char = char_q;
    end
  end

  // Memory read port select
  assign rd_en   = cmd.copy_step || (cmd.rd_issue && hit_q);
  assign rd_addr = cmd.copy_step ? (sweep + ADDR_W'(COLUMNS)) : ADDR_W'(idx_q);

  // Cell memory
  always_ff @(posedge clk) begin
    if (char_we) char_mem[wr_addr] <= wr_char;
    if (attr_we) attr_mem[wr_addr] <= wr_attr;
    if (rd_en) begin
      rd_char <= char_mem[rd_addr];
      rd_attr <= attr_mem[rd_addr];
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q  <= in_cmd;
      char_q <= s_tdata[7:0];
      idx_q  <= in_idx;
      hit_q  <= (in_cmd == tccs_pkg::CMD_READ) && (32'(in_idx) < CELLS);
    end
    copy_addr <= sweep;
  end

  // Cursor, sweep and scroll flag
  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      sweep      <= '0;
      scrolled_q <= 1'b0;
      copy_pend  <= 1'b0;
    end else begin
      copy_pend <= cmd.copy_step;
      if (cmd.load) scrolled_q <= 1'b0;
      if (cmd.put_exec) begin
        col        <= col_b[tccs_pkg::COL_W-1:0];
        row        <= row_new;
        scrolled_q <= need_scroll;
        sweep      <= '0;
      end else if (cmd.clear_init) begin
        col   <= '0;
        row   <= '0;
        sweep <= '0;
      end else if (cmd.fill_init) begin
        sweep <= ADDR_W'(CELLS - COLUMNS);
      end else if (cmd.copy_step || cmd.blank_step) begin
        sweep <= sweep + ADDR_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pos      <= pos_full[tccs_pkg::POS_W-1:0];
      out_char     <= hit_q ? rd_char : '0;
      out_attr     <= hit_q ? rd_attr : '0;
      out_scrolled <= scrolled_q;
    end
  end

  assign m_tdata = {5'd0, out_attr, out_char, out_pos};
  assign m_tuser = out_scrolled;

  // Status to controller
  always_comb begin
    stat             = '0;
    stat.cmd         = cmd_q;
    stat.need_scroll = need_scroll;
    stat.copy_last   = (sweep == ADDR_W'(CELLS - COLUMNS - 1));
    stat.blank_last  = (sweep == ADDR_W'(CELLS - 1));
    stat.out_busy    = m_tvalid && !m_tready;
  end

endmodule

`default_nettype wire

// File: hw/rtl/text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text-mode character cell engine with cursor, wrap, scroll and clear.
// ----------------------------------------------------------------------------
//  Channel  Dir  Signals                      Contents
//  s_*      in   s_tvalid/s_tready/s_tdata    request: cmd, char_code, cell_index
//                s_tuser
//  m_*      out  m_tvalid/m_tready/m_tdata    result: cursor_position, cell_char,
//                m_tuser                      cell_attribute, scrolled
//
//  Clear and a put that scrolls sweep the screen one cell per cycle through the
//  single memory write port. One request is in flight at a time; a new one is
//  taken while the previous result still waits in the output register, and
//  then holds until it drains. rst (synchronous) homes the cursor; cell
//  contents are undefined until a clear or scroll writes them.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_scroll #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // char_code[7:0], cell_index[18:8], zero pad
  input  wire logic [1:0]  s_tuser,   // cmd[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // cursor_position[10:0], cell_char[18:11],
                                      // cell_attribute[26:19], zero pad
  output logic [0:0]       m_tuser    // scrolled[0]
);

  tccs_pkg::dp_cmd_t  dp_cmd;
  tccs_pkg::dp_stat_t dp_stat;

  // Sequencer
  tccs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // Cell store and cursor datapath
  tccs_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (dp_cmd),
    .stat     (dp_stat)
  );

endmodule

`default_nettype wire

// File: hw/rtl/tccs_checker.sv
// ----------------------------------------------------------------------------
// tccs_checker
// Port-level checks of the text console, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_cursor_scroll_assert.svh"

module tccs_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [0:0]  m_tuser
);

  // Stalled result stays offered
  `TCCS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

  // Only one request in flight
  `TCCS_ASSERT_NEXT(a_single_req, s_tvalid && s_tready, !s_tready)

  // Reported cursor is on the screen
  `TCCS_ASSERT_NOW(a_pos_range, m_tvalid, 32'(m_tdata[10:0]) < 32'(ROWS * COLUMNS))

  // After a scroll the cursor sits at the start of the bottom row
  `TCCS_ASSERT_NOW(a_scroll_home, m_tvalid && m_tuser[0], m_tdata[10:0] == 11'((ROWS - 1) * COLUMNS))

endmodule

bind text_console_cursor_scroll tccs_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tccs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll testbench
// Drives put, clear, read and unused-code requests into the text console
// engine and checks every result against a cell-accurate screen model kept
// in a scoreboard class. Traffic is mostly lines of text that wrap and scroll,
// mixed with cell reads, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELL_COUNT  = COLUMNS * ROWS;
  localparam int CYCLE_LIMIT = 12_000_000;
  localparam int HOLD_AT     = 60;    // request count that starts the long stall
  localparam int HOLD_LEN    = 400;
  localparam int PHASE_ITEMS = 205;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [tccs_pkg::POS_W-1:0]  position;
    logic [tccs_pkg::BYTE_W-1:0] ch;
    logic [tccs_pkg::BYTE_W-1:0] attr;
    logic                        scrolled;
  } console_result_t;

  // Screen model plus queue of results still owed by the block
  class console_scoreboard;
    logic [15:0]                 cells [CELL_COUNT];
    logic [tccs_pkg::COL_W-1:0]  cursor_col;
    logic [tccs_pkg::ROW_W-1:0]  cursor_row;
    bit                          screen_defined;
    console_result_t             expected_results [$];
    int                          failures;
    int                          checked;
    int                          n_put, n_clear, n_read, n_unused, n_scroll, n_wrap, n_far_read;

    function new();
      for (int i = 0; i < CELL_COUNT; i++) cells[i] = '0;
      cursor_col = '0;
      cursor_row = '0;
    endfunction

    function logic [tccs_pkg::POS_W-1:0] cursor_pos();
      int p;
      p = cursor_row * COLUMNS + cursor_col;
      return p[tccs_pkg::POS_W-1:0];
    endfunction

    function int pending_count();
      return expected_results.size();
    endfunction

    // Cursor motion, cell write, wrap and scroll for one byte
    function bit apply_put(logic [tccs_pkg::BYTE_W-1:0] ch);
      int pos;
      if (ch == tccs_pkg::CHAR_CR) begin
        cursor_col = '0;
      end else if (ch == tccs_pkg::CHAR_LF) begin
        cursor_col = '0;
        cursor_row = cursor_row + 1'b1;
      end else begin
        pos = cursor_row * COLUMNS + cursor_col;
        cells[pos][7:0] = ch;
        cursor_col = cursor_col + 1'b1;
      end
      if (cursor_col >= COLUMNS) begin
        cursor_col = '0;
        cursor_row = cursor_row + 1'b1;
        n_wrap++;
      end
      if (cursor_row >= ROWS) begin
        for (int i = 0; i < COLUMNS * (ROWS - 1); i++) cells[i] = cells[i + COLUMNS];
        for (int i = COLUMNS * (ROWS - 1); i < CELL_COUNT; i++)
          cells[i] = {tccs_pkg::BLANK_ATTR, tccs_pkg::BLANK_CHAR};
        cursor_row = tccs_pkg::ROW_W'(ROWS - 1);
        n_scroll++;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_request(tccs_pkg::cmd_t cmd, logic [tccs_pkg::BYTE_W-1:0] ch,
                               logic [tccs_pkg::IDX_W-1:0] idx);
      console_result_t r;
      r = '0;
      case (cmd)
        tccs_pkg::CMD_PUT: begin
          n_put++;
          r.scrolled = apply_put(ch);
        end
        tccs_pkg::CMD_CLEAR: begin
          n_clear++;
          for (int i = 0; i < CELL_COUNT; i++)
            cells[i] = {tccs_pkg::BLANK_ATTR, tccs_pkg::BLANK_CHAR};
          cursor_col = '0;
          cursor_row = '0;
          screen_defined = 1'b1;
        end
        tccs_pkg::CMD_READ: begin
          n_read++;
          if (idx < CELL_COUNT) begin
            r.ch   = cells[idx][7:0];
            r.attr = cells[idx][15:8];
          end else begin
            n_far_read++;
          end
        end
        default: n_unused++;
      endcase
      r.position = cursor_pos();
      expected_results.push_back(r);
    endfunction

    function void report(string field, int exp_val, int got_val);
      if (failures < MAX_REPORTS)
        $display("[%0t] result %0d: %s expected %0d, got %0d",
                 $time, checked, field, exp_val, got_val);
    endfunction

    function void check_result(console_result_t got);
      console_result_t exp_r;
      bit bad;
      checked++;
      if (expected_results.size() == 0) begin
        if (failures < MAX_REPORTS)
          $display("[%0t] result %0d arrived with nothing outstanding", $time, checked);
        failures++;
        return;
      end
      exp_r = expected_results.pop_front();
      bad = 1'b0;
      if (got.position != exp_r.position) begin
        report("cursor_position", exp_r.position, got.position);
        bad = 1'b1;
      end
      if (got.ch != exp_r.ch) begin
        report("cell_char", exp_r.ch, got.ch);
        bad = 1'b1;
      end
      if (got.attr != exp_r.attr) begin
        report("cell_attribute", exp_r.attr, got.attr);
        bad = 1'b1;
      end
      if (got.scrolled != exp_r.scrolled) begin
        report("scrolled", exp_r.scrolled, got.scrolled);
        bad = 1'b1;
      end
      if (bad) failures++;
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [23:0]        s_tdata = '0;     // char_code[7:0], cell_index[18:8], zero pad
  logic [1:0]         s_tuser = '0;     // cmd[1:0]
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [31:0]        m_tdata;          // cursor_position[10:0], cell_char[18:11],
                                        // cell_attribute[26:19], zero pad
  logic [0:0]         m_tuser;          // scrolled[0]

  console_scoreboard  sb = new();
  int                 sender_idle_pct = 0;
  int                 receiver_stall_pct = 0;
  int                 accepted_total = 0;
  int                 hold_left = 0;
  bit                 hold_done = 1'b0;
  int                 cycle_count = 0;

  text_console_cursor_scroll #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("text_console_cursor_scroll verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_total == HOLD_AT) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    console_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.position = m_tdata[10:0];
      got.ch       = m_tdata[18:11];
      got.attr     = m_tdata[26:19];
      got.scrolled = m_tuser[0];
      sb.check_result(got);
    end
  end

  // One request, with an optional random gap ahead of it
  task automatic send_request(tccs_pkg::cmd_t cmd, logic [tccs_pkg::BYTE_W-1:0] ch,
                              logic [tccs_pkg::IDX_W-1:0] idx);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {5'd0, idx, ch};
    do @(posedge clk); while (!s_tready);
    sb.note_request(cmd, ch, idx);
    accepted_total <= accepted_total + 1;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_count() != 0);
  endtask

  // Any index, in range or not
  function automatic logic [tccs_pkg::IDX_W-1:0] any_cell();
    return tccs_pkg::IDX_W'($urandom_range(2047));
  endfunction

  // Read address: near the cursor, anywhere on screen, or past the end.
  // In-range cells are only read once a clear has defined the whole screen.
  function automatic logic [tccs_pkg::IDX_W-1:0] pick_cell();
    int sel;
    int p;
    if (!sb.screen_defined) return tccs_pkg::IDX_W'($urandom_range(2047, CELL_COUNT));
    sel = $urandom_range(99);
    if (sel < 50) begin
      p = int'(sb.cursor_pos()) - int'($urandom_range(2 * COLUMNS));
      if (p < 0) p = 0;
      return p[tccs_pkg::IDX_W-1:0];
    end
    if (sel < 90) return tccs_pkg::IDX_W'($urandom_range(CELL_COUNT - 1));
    return any_cell();
  endfunction

  // Lines of text with interleaved reads, occasional clears and noise; short lines mostly, a few that wrap
  task automatic type_text(int target);
    int made;
    int pick;
    int len;
    tccs_pkg::cmd_t cmd;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        send_request(tccs_pkg::CMD_CLEAR, 8'($urandom_range(255)), any_cell());
        made++;
      end else if (pick < 7) begin
        // noise: any code, any fields
        repeat ($urandom_range(1, 3)) begin
          cmd = tccs_pkg::cmd_t'($urandom_range(3));
          if (cmd == tccs_pkg::CMD_READ)
            send_request(cmd, 8'($urandom_range(255)), pick_cell());
          else
            send_request(cmd, 8'($urandom_range(255)), any_cell());
          if (cmd != tccs_pkg::CMD_NOP) made++;
        end
      end else begin
        if (pick < 80)      len = $urandom_range(10);
        else if (pick < 95) len = $urandom_range(60, 11);
        else                len = $urandom_range(170, 70);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(99) < 12)
            send_request(tccs_pkg::CMD_READ, 8'($urandom_range(255)), pick_cell());
          else
            send_request(tccs_pkg::CMD_PUT, 8'($urandom_range(255)), any_cell());
          made++;
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_request(tccs_pkg::CMD_PUT, tccs_pkg::CHAR_CR, any_cell());
          send_request(tccs_pkg::CMD_PUT, tccs_pkg::CHAR_LF, any_cell());
          made += 2;
        end else if (pick < 90) begin
          send_request(tccs_pkg::CMD_PUT, tccs_pkg::CHAR_LF, any_cell());
          made++;
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: put on an unwritten screen, unused code, far reads, clear,
    // byte extremes, carriage return and line feed
    send_request(tccs_pkg::CMD_PUT,   8'h41,  11'd0);
    send_request(tccs_pkg::CMD_NOP,   8'hFF,  11'h7FF);
    send_request(tccs_pkg::CMD_READ,  8'h00,  11'd2000);
    send_request(tccs_pkg::CMD_READ,  8'hFF,  11'd2047);
    send_request(tccs_pkg::CMD_CLEAR, 8'h00,  11'd0);
    send_request(tccs_pkg::CMD_READ,  8'h00,  11'd0);
    send_request(tccs_pkg::CMD_READ,  8'h00,  11'(CELL_COUNT - 1));
    send_request(tccs_pkg::CMD_PUT,   8'h00,  11'd0);
    send_request(tccs_pkg::CMD_PUT,   8'hFF,  11'h7FF);
    send_request(tccs_pkg::CMD_PUT,   tccs_pkg::CHAR_CR, 11'd0);
    send_request(tccs_pkg::CMD_READ,  8'h00,  11'd0);
    send_request(tccs_pkg::CMD_READ,  8'h00,  11'd1);
    send_request(tccs_pkg::CMD_PUT,   tccs_pkg::CHAR_LF, 11'd0);
    send_request(tccs_pkg::CMD_PUT,   8'h55,  11'h2AA);
    send_request(tccs_pkg::CMD_PUT,   8'hAA,  11'h555);
    send_request(tccs_pkg::CMD_READ,  8'h00,  11'(COLUMNS));
    send_request(tccs_pkg::CMD_READ,  8'h00,  11'd2000);
    send_request(tccs_pkg::CMD_NOP,   8'h00,  11'd0);
    drain_results();

    // Random text under four idling patterns, draining between them
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  receiver_stall_pct <= 0;  end
        1: begin sender_idle_pct = 71; receiver_stall_pct <= 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct <= 71; end
        default: begin sender_idle_pct = 11; receiver_stall_pct <= 11; end
      endcase
      type_text(PHASE_ITEMS);
      drain_results();
    end

    // Any late or extra result shows up here as unexpected
    repeat (CELL_COUNT + 16) @(posedge clk);

    $display("Run: %0d requests, %0d puts (%0d line wraps, %0d scroll-ups), %0d clears,",
             sb.n_put + sb.n_clear + sb.n_read + sb.n_unused, sb.n_put, sb.n_wrap,
             sb.n_scroll, sb.n_clear);
    $display("     %0d reads (%0d past the screen), %0d unused codes, %0d results checked",
             sb.n_read, sb.n_far_read, sb.n_unused, sb.checked);
    if (sb.failures == 0 && sb.pending_count() == 0) begin
      $display("text_console_cursor_scroll verification clean");
    end else begin
      $display("text_console_cursor_scroll verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/tccs_pkg.sv
hw/rtl/tccs_ctrl.sv
hw/rtl/tccs_datapath.sv
hw/rtl/text_console_cursor_scroll.sv
hw/rtl/tccs_checker.sv
tb/testbench.sv
